@@ design/circular_buffer_deque_defines.svh @@
// assertion macros shared by the deque rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CIRCULAR_BUFFER_DEQUE_DEFINES_SVH
`define CIRCULAR_BUFFER_DEQUE_DEFINES_SVH

// same-cycle implication, masked during reset
`define CBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/cbd_pkg.sv @@
// types and fixed constants of the circular buffer deque
// no dependencies; used by the channel interfaces and the top level
package cbd_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

endpackage

@@ design/cbd_if.sv @@
// valid/ready channel interfaces of the circular buffer deque
// depends on cbd_pkg for the operation and status codes
interface cbd_req_if import cbd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   op_type                     op;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

interface cbd_rsp_if import cbd_pkg::*; #(
   parameter int unsigned OCC_W = 5
) ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  popped;
   status_type                 status;
   logic [OCC_W-1:0]           occupancy;

   modport source (output valid, output popped, output status, output occupancy, input ready);
   modport sink (input valid, input popped, input status, input occupancy, output ready);
endinterface

@@ design/cbd_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
module cbd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ design/circular_buffer_deque.sv @@
// Double-ended queue of DEPTH signed 32-bit words kept in a circular single-port-pair RAM.
// A request pushes at the front or rear, or pops from the front or rear; each request
// produces exactly one response carrying the popped word (zero unless a pop succeeded),
// a status (ok, overflow on a push to a full deque, underflow on a pop from an empty one)
// and the occupancy after the operation. One request is taken per clock; its response is
// presented the cycle after the transfer, once the RAM's registered read returns the
// popped word, and the response register holds it while the sink stalls, during which no
// new request is taken. A push into an empty deque lands in slot 0, and popping the last
// entry returns both ends to slot 0. There is no clearing pass: slots are defined by the
// pushes that write them. Depends on cbd_pkg, cbd_if.sv and cbd_ram.
`include "circular_buffer_deque_defines.svh"

module circular_buffer_deque import cbd_pkg::*; #(
   parameter int unsigned DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   cbd_req_if.sink    req,
   cbd_rsp_if.source  rsp
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pop_ok_ff;
   status_type       s1_status_ff;
   logic [CNT_W-1:0] s1_occ_ff;

   logic             req_fire;
   logic             full, empty;
   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic             wr_en, rd_en, pop_ok;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   status_type       status;
   logic [VALUE_W-1:0] rd_data;
   logic [IDX_W-1:0] span;

   // the stage may refill whenever its held response leaves
   assign req.ready = !reset && (!s1_valid_ff || rsp.ready);
   assign req_fire  = req.valid && req.ready;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign tail_inc = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? IDX_W'(DEPTH - 1) : tail_ff - 1'b1;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      pop_ok   = 1'b0;
      status   = ST_OK;
      if (req_fire) begin
         case (req.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
               if (full) begin
                  status = ST_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (empty) begin
                     head_in = '0;
                     tail_in = '0;
                     wr_addr = '0;
                  end else if (req.op == OP_PUSH_FRONT) begin
                     head_in = head_dec;
                     wr_addr = head_dec;
                  end else begin
                     tail_in = tail_inc;
                     wr_addr = tail_inc;
                  end
               end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
               if (empty) begin
                  status = ST_UNDERFLOW;
               end else begin
                  rd_en    = 1'b1;
                  pop_ok   = 1'b1;
                  count_in = count_ff - 1'b1;
                  if (req.op == OP_POP_FRONT) begin
                     rd_addr = head_ff;
                     head_in = head_inc;
                  end else begin
                     rd_addr = tail_ff;
                     tail_in = tail_dec;
                  end
                  // last entry gone: both ends go home
                  if (count_ff == CNT_W'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end
               end
            end
            default: begin
               status = ST_OK;
            end
         endcase
      end
   end

   cbd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign s1_valid_in = req_fire || (s1_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pop_ok_ff <= pop_ok;
         s1_status_ff <= status;
         s1_occ_ff    <= count_in;
      end
   end

   // read data stays put while stalled since no new pop reads during a stall
   assign rsp.valid     = s1_valid_ff;
   assign rsp.popped    = s1_pop_ok_ff ? rd_data : '0;
   assign rsp.status    = s1_status_ff;
   assign rsp.occupancy = s1_occ_ff;

   // distance from front to rear, modulo depth, for the occupancy check
   assign span = (tail_ff >= head_ff) ? tail_ff - head_ff
                                      : IDX_W'(DEPTH - 1) - head_ff + tail_ff + 1'b1;

   `CBD_ASSERT_NOW(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH),
      "occupancy exceeds depth")
   `CBD_ASSERT_NOW(a_empty_home, clock, reset, empty, head_ff == '0 && tail_ff == '0,
      "empty deque with ends away from slot 0")
   `CBD_ASSERT_NOW(a_span, clock, reset, !empty, CNT_W'(span) + 1'b1 == count_ff,
      "end pointers disagree with occupancy")
   `CBD_ASSERT_NOW(a_rd_free, clock, reset, rd_en, !s1_valid_ff || rsp.ready,
      "ram read issued while response stage is held")
   `CBD_ASSERT_NEXT(a_pop_resp, clock, reset, rd_en, s1_valid_ff && s1_pop_ok_ff,
      "successful pop not flagged in the response stage")

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the circular buffer deque
// depends on cbd_pkg, the cbd_if channel interfaces and the circular_buffer_deque rtl
`timescale 1ns / 1ps

module tb_top;
   import cbd_pkg::*;

   localparam int unsigned DEPTH = 16;
   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned OCC_W = $clog2(DEPTH + 1);
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef logic signed [VALUE_W-1:0] word_type;

   typedef struct {
      word_type         popped;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } deque_result_type;

   logic clock;
   logic reset;

   cbd_req_if req_if ();
   cbd_rsp_if #(.OCC_W(OCC_W)) rsp_if ();

   circular_buffer_deque #(.DEPTH(DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // deque shadow state
   word_type         shadow_slots [DEPTH];
   logic [IDX_W-1:0] front_idx;
   logic [IDX_W-1:0] rear_idx;
   logic [OCC_W-1:0] held;

   deque_result_type pending_rsp [$];

   bit          idle_en;
   int unsigned stall_left;
   int unsigned stall_pick;
   int unsigned quiet_cycles;
   int unsigned mismatch_count;
   int unsigned n_ops, n_pops_ok, n_overflow, n_underflow, n_full, n_empty;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_en || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 15))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -1;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic deque_result_type apply_deque_op(op_type op, word_type word);
      deque_result_type r;
      r.popped = '0;
      r.status = ST_OK;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
         if (held == DEPTH) begin
            r.status = ST_OVERFLOW;
         end else begin
            if (held == 0) begin
               front_idx = '0;
               rear_idx  = '0;
               shadow_slots[0] = word;
            end else if (op == OP_PUSH_FRONT) begin
               front_idx = front_idx - 1'b1;
               shadow_slots[front_idx] = word;
            end else begin
               rear_idx = rear_idx + 1'b1;
               shadow_slots[rear_idx] = word;
            end
            held = held + 1'b1;
         end
      end else begin
         if (held == 0) begin
            r.status = ST_UNDERFLOW;
         end else begin
            if (op == OP_POP_FRONT) begin
               r.popped  = shadow_slots[front_idx];
               front_idx = front_idx + 1'b1;
            end else begin
               r.popped = shadow_slots[rear_idx];
               rear_idx = rear_idx - 1'b1;
            end
            held = held - 1'b1;
            if (held == 0) begin
               front_idx = '0;
               rear_idx  = '0;
            end
         end
      end
      r.occupancy = held;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_op(input op_type op, input word_type word);
      int unsigned gap;
      deque_result_type r;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op    <= op;
      req_if.value <= word;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      r = apply_deque_op(op, word);
      pending_rsp.push_back(r);
      n_ops++;
      if (r.status == ST_OVERFLOW) n_overflow++;
      if (r.status == ST_UNDERFLOW) n_underflow++;
      if (r.status == ST_OK && (op == OP_POP_FRONT || op == OP_POP_REAR)) begin
         n_pops_ok++;
         if (held == 0) n_empty++;
      end
      if (r.status == ST_OK && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) && held == DEPTH)
         n_full++;
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         stall_pick = pick_gap();
         if (stall_pick != 0) begin
            stall_left    <= stall_pick - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // compare each response transfer against the oldest prediction
   always @(posedge clock) begin
      deque_result_type exp_r;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            exp_r = pending_rsp.pop_front();
            if (rsp_if.popped !== exp_r.popped)
               report_mismatch($sformatf("popped got %0d expected %0d",
                                         rsp_if.popped, exp_r.popped));
            if (rsp_if.status !== exp_r.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_if.status, exp_r.status));
            if (rsp_if.occupancy !== exp_r.occupancy)
               report_mismatch($sformatf("occupancy got %0d expected %0d",
                                         rsp_if.occupancy, exp_r.occupancy));
         end
      end
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_empty_pops();
      send_op(OP_POP_FRONT, pick_word());
      send_op(OP_POP_REAR, pick_word());
   endtask

   // last entry leaves from the front, so both ends go back to slot 0
   task automatic test_single_entry();
      send_op(OP_PUSH_REAR, 32'sh8000_0000);
      send_op(OP_PUSH_FRONT, 32'sh7fff_ffff);
      send_op(OP_POP_REAR, pick_word());
      send_op(OP_POP_FRONT, pick_word());
   endtask

   task automatic test_fill_to_full();
      word_type w;
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0: w = 32'sh7fff_ffff;
            1: w = 32'sh8000_0000;
            2: w = '0;
            3: w = -1;
            default: w = pick_word();
         endcase
         send_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, w);
      end
      send_op(OP_PUSH_FRONT, pick_word());
      send_op(OP_PUSH_REAR, pick_word());
   endtask

   task automatic test_random_mix(input int unsigned n_items);
      for (int i = 0; i < n_items; i++) begin
         if (i % 60 == 0) idle_en = ($urandom_range(0, 3) != 0);
         send_op(op_type'($urandom_range(0, 3)), pick_word());
      end
      idle_en = 1'b1;
   endtask

   // fill to full then drain to empty, with a few refused ops at the ends
   task automatic test_fill_drain(input int unsigned n_items);
      bit     filling;
      bit     push;
      bit     at_front;
      op_type op;
      filling = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         if (held == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
         if (held == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
         if ($urandom_range(0, 49) == 0) filling = !filling;
         if (i % 90 == 45) idle_en = !idle_en;
         push     = filling ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 15);
         at_front = $urandom_range(0, 1);
         if (push) op = at_front ? OP_PUSH_FRONT : OP_PUSH_REAR;
         else      op = at_front ? OP_POP_FRONT : OP_POP_REAR;
         send_op(op, pick_word());
      end
      idle_en = 1'b1;
   endtask

   task automatic test_back_to_back(input int unsigned n_items);
      idle_en = 1'b0;
      for (int i = 0; i < n_items; i++)
         send_op(op_type'($urandom_range(0, 3)), pick_word());
      idle_en = 1'b1;
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.op    = OP_PUSH_FRONT;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      idle_en      = 1'b1;
      stall_left   = 0;
      quiet_cycles = 0;
      front_idx    = '0;
      rear_idx     = '0;
      held         = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_single_entry();
      test_fill_to_full();
      test_random_mix(300);
      test_fill_drain(380);
      test_back_to_back(150);
      req_if.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("ran %0d operations, %0d pops returned a word, %0d overflow and %0d underflow",
               n_ops, n_pops_ok, n_overflow, n_underflow);
      $display("deque filled %0d times and emptied by a pop %0d times", n_full, n_empty);
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
